### rtl/core/dpf_pkg.sv
package dpf_pkg;

   localparam int DEPTH_DEFAULT = 64;

   localparam int ACTION_W = 2;
   localparam int ID_W = 16;
   localparam int TS_W = 32;
   localparam int LIMIT_W = 7;
   localparam int COUNT_W = 7;
   localparam int ENTRY_W = 2 * ID_W + TS_W;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;
   localparam logic [COUNT_W-1:0] COUNT_MAX = 7'd127;

   localparam logic [ACTION_W-1:0] ACT_ADD = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_FORWARD = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_COUNT = 2'd2;

   typedef struct packed {
      logic accept;
      logic scan;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic none_to_scan;
      logic scan_last;
   } status_type;

endpackage

### rtl/core/dpf_req_if.sv
interface dpf_req_if;
   logic valid;
   logic ready;
   logic [dpf_pkg::ACTION_W-1:0] action;
   logic [dpf_pkg::ID_W-1:0] source;
   logic [dpf_pkg::ID_W-1:0] destination;
   logic [dpf_pkg::TS_W-1:0] timestamp;
   logic [dpf_pkg::TS_W-1:0] start_time;
   logic [dpf_pkg::TS_W-1:0] end_time;

   modport source_mp (
      output valid, action, source, destination, timestamp, start_time, end_time,
      input ready
   );
   modport sink (
      input valid, action, source, destination, timestamp, start_time, end_time,
      output ready
   );
endinterface

### rtl/core/dpf_rsp_if.sv
interface dpf_rsp_if;
   logic valid;
   logic ready;
   logic added;
   logic packet_valid;
   logic [dpf_pkg::ID_W-1:0] out_source;
   logic [dpf_pkg::ID_W-1:0] out_destination;
   logic [dpf_pkg::TS_W-1:0] out_timestamp;
   logic [dpf_pkg::COUNT_W-1:0] match_count;

   modport source_mp (
      output valid, added, packet_valid, out_source, out_destination, out_timestamp,
             match_count,
      input ready
   );
   modport sink (
      input valid, added, packet_valid, out_source, out_destination, out_timestamp,
            match_count,
      output ready
   );
endinterface

### rtl/core/dpf_ctrl.sv
module dpf_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  dpf_pkg::status_type status,
   output dpf_pkg::cmd_type    cmd
);

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_SCAN   = 4'b0010,
      S_DRAIN  = 4'b0100,
      S_FINISH = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in = status.none_to_scan ? S_FINISH : S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (status.scan_last) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (out_free) begin
               cmd.finish = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_finish_free: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> out_free)
      else $error("result loaded while output register still full");

   a_accept_scan: assert property (@(posedge clock) disable iff (reset)
      (cmd.accept && !status.none_to_scan) |=> state_ff == S_SCAN)
      else $error("scan did not start after request");

   a_rsp_rise: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.finish))
      else $error("response raised without finish");

endmodule

### rtl/core/dpf_dpath.sv
module dpf_dpath #(
   parameter int DEPTH = dpf_pkg::DEPTH_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  dpf_pkg::cmd_type                   cmd,
   output dpf_pkg::status_type                status,
   input  logic                               csr_wr_en,
   input  logic [dpf_pkg::LIMIT_W-1:0]        csr_wr_data,
   input  logic [dpf_pkg::ACTION_W-1:0]       req_action,
   input  logic [dpf_pkg::ID_W-1:0]           req_source,
   input  logic [dpf_pkg::ID_W-1:0]           req_destination,
   input  logic [dpf_pkg::TS_W-1:0]           req_timestamp,
   input  logic [dpf_pkg::TS_W-1:0]           req_start_time,
   input  logic [dpf_pkg::TS_W-1:0]           req_end_time,
   output logic                               rsp_added,
   output logic                               rsp_packet_valid,
   output logic [dpf_pkg::ID_W-1:0]           rsp_out_source,
   output logic [dpf_pkg::ID_W-1:0]           rsp_out_destination,
   output logic [dpf_pkg::TS_W-1:0]           rsp_out_timestamp,
   output logic [dpf_pkg::COUNT_W-1:0]        rsp_match_count
);

   localparam int SLOT_W = $clog2(DEPTH);
   localparam int OCC_W = $clog2(DEPTH + 1);
   localparam int LW = (OCC_W > dpf_pkg::LIMIT_W) ? OCC_W : dpf_pkg::LIMIT_W;
   localparam int EW = dpf_pkg::ENTRY_W;
   localparam int TS_W = dpf_pkg::TS_W;
   localparam int ID_W = dpf_pkg::ID_W;

   logic [EW-1:0] mem [DEPTH];
   logic [EW-1:0] rd_data_ff;
   logic          rd_valid_ff;

   logic [SLOT_W-1:0] head_ff, head_in;
   logic [OCC_W-1:0]  occ_ff, occ_in;
   logic [dpf_pkg::LIMIT_W-1:0] limit_ff;

   logic [dpf_pkg::ACTION_W-1:0] act_ff;
   logic [ID_W-1:0] src_ff, dst_ff;
   logic [TS_W-1:0] ts_ff, lo_ff, hi_ff;

   logic [SLOT_W-1:0] slot_ff;
   logic [OCC_W-1:0]  left_ff, left_in;
   logic              dup_ff;
   logic [OCC_W-1:0]  cnt_ff;

   logic              added_ff;
   logic              pkt_valid_ff;
   logic [ID_W-1:0]   out_src_ff;
   logic [ID_W-1:0]   out_dst_ff;
   logic [TS_W-1:0]   out_ts_ff;
   logic [dpf_pkg::COUNT_W-1:0] out_cnt_ff;

   logic [LW-1:0]     lim_eff;
   logic              evict;
   logic [OCC_W:0]    wr_sum;
   logic [SLOT_W-1:0] wr_slot;
   logic              wr_en;
   logic [EW-1:0]     cand;
   logic [LW-1:0]     cnt_ext;
   logic [dpf_pkg::COUNT_W-1:0] cnt_sat;
   logic              hit;

   function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
      logic [SLOT_W-1:0] r;
      r = (s == SLOT_W'(DEPTH - 1)) ? '0 : s + 1'b1;
      return r;
   endfunction

   assign cand = {src_ff, dst_ff, ts_ff};

   always_comb begin
      if (req_action == dpf_pkg::ACT_ADD || req_action == dpf_pkg::ACT_COUNT) begin
         left_in = occ_ff;
      end else if (req_action == dpf_pkg::ACT_FORWARD) begin
         left_in = (occ_ff != '0) ? OCC_W'(1) : '0;
      end else begin
         left_in = '0;
      end
   end

   assign status.none_to_scan = (left_in == '0);
   assign status.scan_last = (left_ff == OCC_W'(1));

   always_comb begin
      if (limit_ff == '0) begin
         lim_eff = LW'(1);
      end else if (LW'(limit_ff) > LW'(DEPTH)) begin
         lim_eff = LW'(DEPTH);
      end else begin
         lim_eff = LW'(limit_ff);
      end
   end

   assign evict = (LW'(occ_ff) >= lim_eff);
   assign wr_sum = (OCC_W+1)'(head_ff) + (OCC_W+1)'(occ_ff);
   assign wr_slot = (wr_sum >= (OCC_W+1)'(DEPTH)) ? SLOT_W'(wr_sum - (OCC_W+1)'(DEPTH))
                                                 : SLOT_W'(wr_sum);
   assign wr_en = cmd.finish && (act_ff == dpf_pkg::ACT_ADD) && !dup_ff;

   assign hit = (rd_data_ff[TS_W +: ID_W] == dst_ff) &&
                (rd_data_ff[TS_W-1:0] >= lo_ff) && (rd_data_ff[TS_W-1:0] <= hi_ff);

   assign cnt_ext = LW'(cnt_ff);
   assign cnt_sat = (cnt_ext > LW'(dpf_pkg::COUNT_MAX)) ? dpf_pkg::COUNT_MAX
                                                        : dpf_pkg::COUNT_W'(cnt_ext);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_slot] <= cand;
      end
      if (cmd.scan) begin
         rd_data_ff <= mem[slot_ff];
      end
   end

   always_comb begin
      head_in = head_ff;
      occ_in = occ_ff;
      if (cmd.finish) begin
         case (act_ff)
            dpf_pkg::ACT_ADD: begin
               if (!dup_ff) begin
                  if (evict) begin
                     head_in = slot_inc(head_ff);
                  end else begin
                     occ_in = occ_ff + 1'b1;
                  end
               end
            end
            dpf_pkg::ACT_FORWARD: begin
               if (occ_ff != '0) begin
                  head_in = slot_inc(head_ff);
                  occ_in = occ_ff - 1'b1;
               end
            end
            default: begin
               head_in = head_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         occ_ff <= '0;
         limit_ff <= dpf_pkg::LIMIT_RESET;
         rd_valid_ff <= 1'b0;
      end else begin
         head_ff <= head_in;
         occ_ff <= occ_in;
         rd_valid_ff <= cmd.scan;
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         act_ff <= req_action;
         src_ff <= req_source;
         dst_ff <= req_destination;
         ts_ff <= req_timestamp;
         lo_ff <= req_start_time;
         hi_ff <= req_end_time;
         slot_ff <= head_ff;
         left_ff <= left_in;
         dup_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         if (cmd.scan) begin
            slot_ff <= slot_inc(slot_ff);
            left_ff <= left_ff - 1'b1;
         end
         if (rd_valid_ff) begin
            if (rd_data_ff == cand) begin
               dup_ff <= 1'b1;
            end
            if (hit) begin
               cnt_ff <= cnt_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         added_ff <= 1'b0;
         pkt_valid_ff <= 1'b0;
         out_src_ff <= '0;
         out_dst_ff <= '0;
         out_ts_ff <= '0;
         out_cnt_ff <= '0;
         case (act_ff)
            dpf_pkg::ACT_ADD: begin
               added_ff <= !dup_ff;
            end
            dpf_pkg::ACT_FORWARD: begin
               if (occ_ff != '0) begin
                  pkt_valid_ff <= 1'b1;
                  out_src_ff <= rd_data_ff[TS_W + ID_W +: ID_W];
                  out_dst_ff <= rd_data_ff[TS_W +: ID_W];
                  out_ts_ff <= rd_data_ff[TS_W-1:0];
               end
            end
            dpf_pkg::ACT_COUNT: begin
               out_cnt_ff <= cnt_sat;
            end
            default: begin
               added_ff <= 1'b0;
            end
         endcase
      end
   end

   assign rsp_added = added_ff;
   assign rsp_packet_valid = pkt_valid_ff;
   assign rsp_out_source = out_src_ff;
   assign rsp_out_destination = out_dst_ff;
   assign rsp_out_timestamp = out_ts_ff;
   assign rsp_match_count = out_cnt_ff;

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= OCC_W'(DEPTH))
      else $error("occupancy above depth");

   a_rd_valid: assert property (@(posedge clock) disable iff (reset)
      rd_valid_ff |-> $past(cmd.scan))
      else $error("compare without memory read");

   a_no_rw: assert property (@(posedge clock) disable iff (reset)
      !(wr_en && cmd.scan))
      else $error("memory written during scan");

endmodule

### rtl/core/dedup_packet_fifo_with_range_count.sv
// Bounded packet FIFO with duplicate filter and destination/time range count.
// req_chan carries one request (action, source, destination, timestamp,
// start_time, end_time); rsp_chan returns exactly one response per request.
// csr_wr_en/csr_wr_data write memory_limit (0 acts as 1, above DEPTH acts
// as DEPTH); write it only while no request is in flight.
// Timing: add and count read every stored packet, one memory read a cycle.
// After the request is accepted the block scans (S_SCAN), drains the last
// compare (S_DRAIN) and loads the response register (S_FINISH); forward of a
// non-empty FIFO reads only the head packet. Forward of an empty FIFO, add or
// count with nothing stored, and the unused action code skip the scan and go
// straight to S_FINISH. The single memory read port makes the scan read one
// packet at a time. req_chan.ready is high only between requests.
// The response sits in an output register; the next request is accepted
// while it waits. If rsp_chan stalls, a finished request waits until the
// register frees, and no further request is taken meanwhile.
// Reset empties the FIFO (head and occupancy to zero), sets memory_limit to
// 64 and drops any pending response. Stored packets need no clearing.
module dedup_packet_fifo_with_range_count #(
   parameter int DEPTH = dpf_pkg::DEPTH_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   dpf_req_if.sink                      req_chan,
   dpf_rsp_if.source_mp                 rsp_chan,
   input  logic                         csr_wr_en,
   input  logic [dpf_pkg::LIMIT_W-1:0]  csr_wr_data
);

   dpf_pkg::cmd_type    cmd;
   dpf_pkg::status_type status;

   dpf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   dpf_dpath #(
      .DEPTH (DEPTH)
   ) u_dpath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data),
      .req_action          (req_chan.action),
      .req_source          (req_chan.source),
      .req_destination     (req_chan.destination),
      .req_timestamp       (req_chan.timestamp),
      .req_start_time      (req_chan.start_time),
      .req_end_time        (req_chan.end_time),
      .rsp_added           (rsp_chan.added),
      .rsp_packet_valid    (rsp_chan.packet_valid),
      .rsp_out_source      (rsp_chan.out_source),
      .rsp_out_destination (rsp_chan.out_destination),
      .rsp_out_timestamp   (rsp_chan.out_timestamp),
      .rsp_match_count     (rsp_chan.match_count)
   );

endmodule
